@@ sv/gtg_pkg.sv @@
// ----------------------------------------------------------------------------
// gtg_pkg
// types, mode constants, trig and sigmoid tables, rounding helpers
// ----------------------------------------------------------------------------
`default_nettype none

package gtg_pkg;

  localparam int unsigned MAX_LEVEL       = 7;
  localparam int unsigned ANGLE_FRAC_BITS = 8;

  localparam logic [1:0] CFG_GAIT_MODE = 2'd0;
  localparam logic [1:0] CFG_DRIVE_UP  = 2'd1;

  localparam logic signed [24:0] TURN_IN_GAIN = 25'sd1314228;
  localparam logic signed [17:0] OFF_LEG_Q16  = 18'sd6554;
  localparam logic signed [17:0] ONE_Q14      = 18'sd16384;

  typedef enum logic [2:0] {
    K_FWD, K_BACK, K_RDRIB, K_LDRIB, K_TURN, K_IN, K_SIDE, K_NONE
  } kind_e;

  typedef enum logic [2:0] {
    OP_AMP, OP_LINE, OP_OFF, OP_GRAV, OP_SPRING
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_RND, S_ASM, S_LOAD
  } state_e;

  typedef struct packed {
    logic [22:0] amp;
    logic [21:0] spring;
    logic [20:0] grav;
    logic [1:0]  sig;
    logic        cyc30;
    logic [2:0]  cap;
    kind_e       kind;
    logic        shifted;
  } mode_t;

  typedef struct packed {
    logic start;
    op_e  op;
    logic mul_en;
    logic rnd_en;
    logic asm_en;
    logic load_en;
  } cmd_t;

  localparam logic [14:0] SIN_TAB [0:90] = '{
    15'd0, 15'd286, 15'd572, 15'd857, 15'd1143, 15'd1428, 15'd1713, 15'd1997,
    15'd2280, 15'd2563, 15'd2845, 15'd3126, 15'd3406, 15'd3686, 15'd3964,
    15'd4240, 15'd4516, 15'd4790, 15'd5063, 15'd5334, 15'd5604, 15'd5872,
    15'd6138, 15'd6402, 15'd6664, 15'd6924, 15'd7182, 15'd7438, 15'd7692,
    15'd7943, 15'd8192, 15'd8438, 15'd8682, 15'd8923, 15'd9162, 15'd9397,
    15'd9630, 15'd9860, 15'd10087, 15'd10311, 15'd10531, 15'd10749, 15'd10963,
    15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
    15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255,
    15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189,
    15'd14330, 15'd14466, 15'd14598, 15'd14726, 15'd14849, 15'd14968,
    15'd15082, 15'd15191, 15'd15296, 15'd15396, 15'd15491, 15'd15582,
    15'd15668, 15'd15749, 15'd15826, 15'd15897, 15'd15964, 15'd16026,
    15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
    15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
  };

  // d in 0..359
  function automatic logic signed [15:0] sin_q14(input logic [8:0] d);
    logic [8:0]  idx;
    logic [15:0] mag;
    logic        neg;
    begin
      neg = 1'b0;
      if (d <= 9'd90) begin
        idx = d;
      end else if (d <= 9'd180) begin
        idx = 9'd180 - d;
      end else if (d <= 9'd270) begin
        idx = d - 9'd180;
        neg = 1'b1;
      end else begin
        idx = 9'd360 - d;
        neg = 1'b1;
      end
      mag = {1'b0, SIN_TAB[idx[6:0]]};
      return neg ? -$signed(mag) : $signed(mag);
    end
  endfunction

  function automatic logic signed [15:0] cos_q14(input logic [8:0] d);
    logic [9:0] e;
    begin
      e = {1'b0, d} + 10'd90;
      if (e >= 10'd360) begin
        e = e - 10'd360;
      end
      return sin_q14(e[8:0]);
    end
  endfunction

  function automatic logic [15:0] sig_q16(input logic [1:0] s, input logic [2:0] lv);
    logic [15:0] t [0:7];
    begin
      case (s)
        2'd0: t = '{16'd5545, 16'd17653, 16'd39008, 16'd55990,
                    16'd62849, 16'd64841, 16'd65360, 16'd65492};
        2'd1: t = '{16'd1812, 16'd6161, 16'd17998, 16'd38016,
                    16'd54687, 16'd62157, 16'd64574, 16'd65269};
        2'd2: t = '{16'd15452, 16'd34572, 16'd52534, 16'd61341,
                    16'd64320, 16'd65196, 16'd65442, 16'd65510};
        default: t = '{default: 16'd0};
      endcase
      return t[lv];
    end
  endfunction

  function automatic mode_t mode_lookup(input logic [3:0] m);
    mode_t r;
    begin
      case (m)
        4'd0:  r = '{23'd6830410, 22'd3400899, 21'd1180308, 2'd0, 1'b0, 3'd7, K_FWD, 1'b0};
        4'd1:  r = '{23'd3748328, 22'd2896036, 21'd273254, 2'd1, 1'b0, 3'd3, K_FWD, 1'b0};
        4'd2:  r = '{23'd2503292, 22'd2202897, 21'd49260, 2'd2, 1'b0, 3'd7, K_FWD, 1'b0};
        4'd3:  r = '{23'd3748328, 22'd2896036, 21'd273254, 2'd1, 1'b0, 3'd7, K_RDRIB, 1'b0};
        4'd4:  r = '{23'd3748328, 22'd2896036, 21'd273254, 2'd1, 1'b0, 3'd7, K_LDRIB, 1'b0};
        4'd5:  r = '{23'd2503292, 22'd2202897, 21'd49516, 2'd2, 1'b0, 3'd7, K_RDRIB, 1'b0};
        4'd6:  r = '{23'd2503292, 22'd2202897, 21'd49516, 2'd2, 1'b0, 3'd7, K_LDRIB, 1'b0};
        4'd7:  r = '{23'd3748328, 22'd2896036, 21'd273254, 2'd1, 1'b0, 3'd7, K_BACK, 1'b0};
        4'd8:  r = '{23'd3748328, 22'd2896036, 21'd273254, 2'd1, 1'b0, 3'd2, K_BACK, 1'b0};
        4'd9:  r = '{23'd938734, 22'd3744209, 21'd46216, 2'd3, 1'b1, 3'd7, K_TURN, 1'b1};
        4'd10: r = '{23'd938734, 22'd3744209, 21'd46216, 2'd3, 1'b1, 3'd7, K_TURN, 1'b0};
        4'd11: r = '{23'd281620, 22'd2732163, 21'd128742, 2'd3, 1'b1, 3'd7, K_IN, 1'b1};
        4'd12: r = '{23'd281620, 22'd2732163, 21'd128742, 2'd3, 1'b1, 3'd7, K_IN, 1'b0};
        4'd13: r = '{23'd750987, 22'd3744209, 21'd46216, 2'd3, 1'b1, 3'd7, K_SIDE, 1'b1};
        4'd14: r = '{23'd750987, 22'd3744209, 21'd46216, 2'd3, 1'b1, 3'd7, K_SIDE, 1'b0};
        default: r = '{23'd0, 22'd0, 21'd0, 2'd3, 1'b0, 3'd7, K_NONE, 1'b0};
      endcase
      return r;
    end
  endfunction

  // round half away from zero, shift by 16 or 14
  function automatic logic signed [42:0] rshr(input logic signed [42:0] v, input logic sh16);
    logic [42:0] mag;
    logic [42:0] r;
    begin
      mag = v[42] ? 43'(-v) : 43'(v);
      if (sh16) begin
        r = (mag + 43'(1 << 15)) >> 16;
      end else begin
        r = (mag + 43'(1 << 13)) >> 14;
      end
      return v[42] ? -$signed(r) : $signed(r);
    end
  endfunction

  // sh is 16 minus the output fraction bits
  function automatic logic [17:0] out18(input logic signed [26:0] v, input int unsigned sh);
    logic [26:0]        mag;
    logic [26:0]        r;
    logic signed [27:0] sv;
    begin
      mag = v[26] ? 27'(-v) : 27'(v);
      r   = (mag + 27'(1 << (sh - 1))) >> sh;
      sv  = v[26] ? -$signed({1'b0, r}) : $signed({1'b0, r});
      if (sv > 28'sd131071) begin
        return 18'h1FFFF;
      end else if (sv < -28'sd131072) begin
        return 18'h20000;
      end else begin
        return sv[17:0];
      end
    end
  endfunction

endpackage

`default_nettype wire

@@ sv/gtg_ctrl.sv @@
// ----------------------------------------------------------------------------
// gtg_ctrl
// sequencer: five multiply/round steps, joint assembly, result load
// ----------------------------------------------------------------------------
`default_nettype none

module gtg_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output gtg_pkg::cmd_t      cmd_o
);
  import gtg_pkg::*;

  state_e state_q, state_d;
  op_e    op_q, op_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_AMP;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    out_valid_d = out_valid_q;
    cmd_o       = '{start: 1'b0, op: op_q, mul_en: 1'b0, rnd_en: 1'b0,
                    asm_en: 1'b0, load_en: 1'b0};
    in_ready_o  = (state_q == S_IDLE);
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          op_d        = OP_AMP;
          state_d     = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = S_RND;
      end
      S_RND: begin
        cmd_o.rnd_en = 1'b1;
        case (op_q)
          OP_AMP:  op_d = OP_LINE;
          OP_LINE: op_d = OP_OFF;
          OP_OFF:  op_d = OP_GRAV;
          OP_GRAV: op_d = OP_SPRING;
          default: op_d = OP_AMP;
        endcase
        state_d = (op_q == OP_SPRING) ? S_ASM : S_MUL;
      end
      S_ASM: begin
        cmd_o.asm_en = 1'b1;
        state_d      = S_LOAD;
      end
      S_LOAD: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_en = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ sv/gtg_dp.sv @@
// ----------------------------------------------------------------------------
// gtg_dp
// gait state, phase and table lookup, shared multiplier, joint assembly
// ----------------------------------------------------------------------------
`default_nettype none

module gtg_dp #(
  parameter int unsigned MAX_LEVEL       = gtg_pkg::MAX_LEVEL,
  parameter int unsigned ANGLE_FRAC_BITS = gtg_pkg::ANGLE_FRAC_BITS
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire gtg_pkg::cmd_t cmd_i,
  input  wire logic          tick_i,
  input  wire logic          cfg_valid_i,
  input  wire logic [1:0]    cfg_index_i,
  input  wire logic [3:0]    cfg_data_i,
  output logic [17:0]        joint_o [0:10],
  output logic               finished_o
);
  import gtg_pkg::*;

  localparam int unsigned OUT_SHIFT = 16 - ANGLE_FRAC_BITS;

  logic [3:0]  mode_q;
  logic        drive_up_q;
  logic [15:0] ts_q;
  logic [5:0]  ts36_q;
  logic [2:0]  level_q;
  logic [12:0] pidx_q;
  logic        done_q;
  logic        tick_q;

  mode_t m;
  assign m = mode_lookup(mode_q);

  logic walk;
  assign walk = (m.kind == K_FWD) || (m.kind == K_BACK) ||
                (m.kind == K_RDRIB) || (m.kind == K_LDRIB);

  // phase from tick count mod 36, which covers both frequencies
  logic [10:0] ph_raw;
  logic [8:0]  ph, ps, ph2;
  logic [9:0]  ph2_raw;
  always_comb begin
    ph_raw = m.cyc30 ? 11'(ts36_q) * 11'd30 : 11'(ts36_q) * 11'd20;
    if (ph_raw >= 11'd720) begin
      ph = 9'(ph_raw - 11'd720);
    end else if (ph_raw >= 11'd360) begin
      ph = 9'(ph_raw - 11'd360);
    end else begin
      ph = ph_raw[8:0];
    end
    if (!m.shifted) begin
      ps = ph;
    end else if (ph >= 9'd180) begin
      ps = ph - 9'd180;
    end else begin
      ps = ph + 9'd180;
    end
    ph2_raw = {ph, 1'b0};
    ph2     = (ph2_raw >= 10'd360) ? 9'(ph2_raw - 10'd360) : ph2_raw[8:0];
  end

  logic signed [15:0] c_q14, sin_ph, cos2;
  assign c_q14  = cos_q14(ps);
  assign sin_ph = sin_q14(ph);
  assign cos2   = cos_q14(ph2);

  // shared multiplier
  logic signed [24:0] r_a_q, r_l_q, r_off_q, r_g_q, r_s_q;
  logic signed [24:0] mul_a;
  logic signed [17:0] mul_b;
  logic               sh16;
  logic signed [42:0] prod_q, rnd;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    sh16  = 1'b0;
    case (cmd_i.op)
      OP_AMP: begin
        mul_a = $signed({2'b00, m.amp});
        if (walk) begin
          mul_b = $signed({2'b00, sig_q16(m.sig, level_q)});
          sh16  = 1'b1;
        end else begin
          mul_b = ONE_Q14 - 18'(c_q14);
        end
      end
      OP_LINE: begin
        mul_a = walk ? r_a_q : TURN_IN_GAIN;
        mul_b = 18'(c_q14);
      end
      OP_OFF: begin
        mul_a = r_l_q;
        mul_b = OFF_LEG_Q16;
        sh16  = 1'b1;
      end
      OP_GRAV: begin
        mul_a = $signed({4'b0000, m.grav});
        mul_b = 18'(sin_ph);
      end
      OP_SPRING: begin
        mul_a = $signed({3'b000, m.spring});
        mul_b = ONE_Q14 - 18'(cos2);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign rnd = rshr(prod_q, sh16);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    if (cmd_i.rnd_en) begin
      case (cmd_i.op)
        OP_AMP:    r_a_q   <= rnd[24:0];
        OP_LINE:   r_l_q   <= rnd[24:0];
        OP_OFF:    r_off_q <= rnd[24:0];
        OP_GRAV:   r_g_q   <= rnd[24:0];
        OP_SPRING: r_s_q   <= rnd[24:0];
        default:   r_s_q   <= r_s_q;
      endcase
    end
  end

  // joint assembly
  logic signed [26:0] jt_q [0:10];
  logic signed [26:0] j [0:11];
  logic signed [26:0] l, off, a, s, g;
  always_comb begin
    l   = 27'(r_l_q);
    off = 27'(r_off_q);
    a   = 27'(r_a_q);
    s   = 27'(r_s_q);
    g   = 27'(r_g_q);
    for (int k = 0; k < 12; k++) begin
      j[k] = '0;
    end
    case (m.kind)
      K_FWD: begin
        j[2] = -l; j[4] = l; j[8] = l; j[10] = -l;
      end
      K_BACK: begin
        j[2] = l; j[4] = -l; j[8] = -l; j[10] = l;
      end
      K_RDRIB: begin
        j[8] = l; j[10] = -l; j[2] = -off; j[4] = off;
      end
      K_LDRIB: begin
        j[2] = -l; j[4] = l; j[8] = off; j[10] = -off;
      end
      K_TURN: begin
        j[0] = -a;
      end
      K_IN: begin
        j[1] = -a; j[5] = a; j[7] = a; j[11] = -a;
        j[2] = -l; j[4] = l; j[8] = -l; j[10] = l;
      end
      K_SIDE: begin
        j[1] = -a; j[5] = a; j[7] = a; j[11] = -a;
      end
      default: begin
        j[0] = '0;
      end
    endcase
    // spring bend goes to the leg on the sway side
    if (g > 27'sd0) begin
      j[2] = j[2] + s;
      j[3] = j[3] - {s[25:0], 1'b0};
      j[4] = j[4] + s;
    end else begin
      j[8]  = j[8] + s;
      j[9]  = j[9] - {s[25:0], 1'b0};
      j[10] = j[10] + s;
    end
    if (j[3] >= 27'sd0) begin
      j[3] = '0;
    end
    if (j[9] >= 27'sd0) begin
      j[9] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.asm_en) begin
      jt_q[0]  <= j[0];
      jt_q[1]  <= j[1] - g;
      jt_q[2]  <= j[2];
      jt_q[3]  <= j[3];
      jt_q[4]  <= j[4];
      jt_q[5]  <= j[5] + g;
      jt_q[6]  <= j[7] - g;
      jt_q[7]  <= j[8];
      jt_q[8]  <= j[9];
      jt_q[9]  <= j[10];
      jt_q[10] <= j[11] + g;
    end
  end

  // state update at result load
  logic [21:0] ts_cyc, p360;
  logic [2:0]  lvl_d, capm;
  logic        done_d;
  always_comb begin
    ts_cyc = m.cyc30 ? ({ts_q, 5'b0} - 22'({ts_q, 1'b0}))
                     : (22'({ts_q, 4'b0}) + 22'({ts_q, 2'b0}));
    p360   = 22'({pidx_q, 8'b0}) + 22'({pidx_q, 6'b0}) +
             22'({pidx_q, 5'b0}) + 22'({pidx_q, 3'b0});
    capm   = (m.cap < 3'(MAX_LEVEL)) ? m.cap : 3'(MAX_LEVEL);
    lvl_d  = walk || (m.kind == K_NONE) ? level_q : 3'd0;
    if (ts_cyc >= p360) begin
      if (drive_up_q && lvl_d < capm) begin
        lvl_d = lvl_d + 3'd1;
      end
      if (!drive_up_q && lvl_d > 3'd1) begin
        lvl_d = lvl_d - 3'd1;
      end
    end
    done_d = done_q;
    if (tick_q && ts_q > (m.cyc30 ? 16'd3000 : 16'd2000)) begin
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= 4'd0;
      drive_up_q <= 1'b1;
      ts_q       <= '0;
      ts36_q     <= '0;
      level_q    <= 3'd1;
      pidx_q     <= 13'd1;
      done_q     <= 1'b0;
      tick_q     <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_GAIT_MODE: mode_q     <= cfg_data_i;
          CFG_DRIVE_UP:  drive_up_q <= cfg_data_i[0];
          default:       mode_q     <= mode_q;
        endcase
      end
      if (cmd_i.start) begin
        tick_q <= tick_i;
      end
      if (cmd_i.load_en && tick_q) begin
        level_q <= lvl_d;
        done_q  <= done_d;
        if (ts_cyc >= p360 && pidx_q != 13'h1FFF) begin
          pidx_q <= pidx_q + 13'd1;
        end
        if (ts_q != 16'hFFFF) begin
          ts_q   <= ts_q + 16'd1;
          ts36_q <= (ts36_q == 6'd35) ? 6'd0 : ts36_q + 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_en) begin
      for (int k = 0; k < 11; k++) begin
        joint_o[k] <= out18(jt_q[k], OUT_SHIFT);
      end
      finished_o <= done_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/gait_trajectory_generator_top.sv @@
// ----------------------------------------------------------------------------
// gait_trajectory_generator_top
// leg joint targets for a small humanoid, one set per gait tick
// ----------------------------------------------------------------------------
// Each accepted item produces one set of eleven leg joint angles (1/256
// degree, saturated to 18 bits) plus a finished flag. A tick of one advances
// gait time by one step (20 or 30 degrees of phase, by mode) and may step the
// amplitude level at a whole gait period; a tick of zero reports the current
// pose. Five products run one after another through a single shared multiplier,
// each a multiply step then a round step, followed by an assembly step and a
// load step that waits while the last result is not yet taken. The input is
// taken again once the result is loaded, even while it waits to be taken.
// Configuration writes are always accepted and should be made while idle.
`default_nettype none

module gait_trajectory_generator_top #(
  parameter int unsigned MAX_LEVEL       = gtg_pkg::MAX_LEVEL,
  parameter int unsigned ANGLE_FRAC_BITS = gtg_pkg::ANGLE_FRAC_BITS
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [3:0]         cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               tick_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [17:0]      turn_angle_o,
  output logic signed [17:0]      right_hip_roll_o,
  output logic signed [17:0]      right_hip_pitch_o,
  output logic signed [17:0]      right_knee_o,
  output logic signed [17:0]      right_ankle_pitch_o,
  output logic signed [17:0]      right_ankle_roll_o,
  output logic signed [17:0]      left_hip_roll_o,
  output logic signed [17:0]      left_hip_pitch_o,
  output logic signed [17:0]      left_knee_o,
  output logic signed [17:0]      left_ankle_pitch_o,
  output logic signed [17:0]      left_ankle_roll_o,
  output logic                    finished_o
);
  import gtg_pkg::*;

  cmd_t        cmd;
  logic [17:0] joint [0:10];

  assign cfg_ready_o = 1'b1;

  gtg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  gtg_dp #(
    .MAX_LEVEL       (MAX_LEVEL),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .tick_i      (tick_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .joint_o     (joint),
    .finished_o  (finished_o)
  );

  assign turn_angle_o        = $signed(joint[0]);
  assign right_hip_roll_o    = $signed(joint[1]);
  assign right_hip_pitch_o   = $signed(joint[2]);
  assign right_knee_o        = $signed(joint[3]);
  assign right_ankle_pitch_o = $signed(joint[4]);
  assign right_ankle_roll_o  = $signed(joint[5]);
  assign left_hip_roll_o     = $signed(joint[6]);
  assign left_hip_pitch_o    = $signed(joint[7]);
  assign left_knee_o         = $signed(joint[8]);
  assign left_ankle_pitch_o  = $signed(joint[9]);
  assign left_ankle_roll_o   = $signed(joint[10]);

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// checks gait_trajectory_generator_top against a cycle-free pose predictor
// ----------------------------------------------------------------------------
// Ticks are sent in phases. Between phases the block is drained and the gait
// mode and drive direction are rewritten. Every returned pose is compared
// joint by joint with the predicted pose.
`default_nettype none

module testbench;
  import gtg_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD      = 80;

  typedef struct {
    longint      amp;
    longint      spring;
    longint      grav;
    int          sig;
    int unsigned cyc;
    int unsigned cap;
    kind_e       kind;
    bit          shifted;
  } gait_params_t;

  typedef struct {
    logic signed [17:0] joint [11];
    logic               fin;
  } pose_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [3:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic tick = 1'b0;
  logic out_ready = 1'b0;
  logic cfg_ready, in_ready, out_valid, finished;
  logic signed [17:0] joint_seen [11];

  gait_trajectory_generator_top dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .tick_i(tick),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .turn_angle_o(joint_seen[0]), .right_hip_roll_o(joint_seen[1]),
    .right_hip_pitch_o(joint_seen[2]), .right_knee_o(joint_seen[3]),
    .right_ankle_pitch_o(joint_seen[4]), .right_ankle_roll_o(joint_seen[5]),
    .left_hip_roll_o(joint_seen[6]), .left_hip_pitch_o(joint_seen[7]),
    .left_knee_o(joint_seen[8]), .left_ankle_pitch_o(joint_seen[9]),
    .left_ankle_roll_o(joint_seen[10]), .finished_o(finished)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  string joint_name [11] = '{"turn_angle", "right_hip_roll", "right_hip_pitch",
    "right_knee", "right_ankle_pitch", "right_ankle_roll", "left_hip_roll",
    "left_hip_pitch", "left_knee", "left_ankle_pitch", "left_ankle_roll"};

  // ---------------- pose predictor ----------------
  int sine_tab [91] = '{
    0, 286, 572, 857, 1143, 1428, 1713, 1997, 2280, 2563,
    2845, 3126, 3406, 3686, 3964, 4240, 4516, 4790, 5063, 5334,
    5604, 5872, 6138, 6402, 6664, 6924, 7182, 7438, 7692, 7943,
    8192, 8438, 8682, 8923, 9162, 9397, 9630, 9860, 10087, 10311,
    10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
    12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
    14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
    15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
    16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
    16384};

  longint sigmoid_tab [3][8] = '{
    '{5545, 17653, 39008, 55990, 62849, 64841, 65360, 65492},
    '{1812, 6161, 17998, 38016, 54687, 62157, 64574, 65269},
    '{15452, 34572, 52534, 61341, 64320, 65196, 65442, 65510}};

  logic [3:0]  gait_sel;
  bit          drive_dir;
  int unsigned tick_count, amp_level, period_idx;
  bit          done_flag;

  function automatic longint round_shift(input longint v, input int sh);
    longint h;
    h = longint'(1) << (sh - 1);
    if (v >= 0) return (v + h) >>> sh;
    return -((-v + h) >>> sh);
  endfunction

  function automatic longint sine_deg(input int unsigned d);
    d = d % 360;
    if (d <= 90) return sine_tab[d];
    if (d <= 180) return sine_tab[180 - d];
    if (d <= 270) return -sine_tab[d - 180];
    return -sine_tab[360 - d];
  endfunction

  function automatic logic signed [17:0] to_angle(input longint v);
    v = round_shift(v, 16 - ANGLE_FRAC_BITS);
    if (v > 131071) v = 131071;
    if (v < -131072) v = -131072;
    return v[17:0];
  endfunction

  function automatic gait_params_t params_of(input logic [3:0] m);
    case (m)
      4'd0:  return '{6830410, 3400899, 1180308, 0, 20, 7, K_FWD, 0};
      4'd1:  return '{3748328, 2896036, 273254, 1, 20, 3, K_FWD, 0};
      4'd2:  return '{2503292, 2202897, 49260, 2, 20, 7, K_FWD, 0};
      4'd3:  return '{3748328, 2896036, 273254, 1, 20, 7, K_RDRIB, 0};
      4'd4:  return '{3748328, 2896036, 273254, 1, 20, 7, K_LDRIB, 0};
      4'd5:  return '{2503292, 2202897, 49516, 2, 20, 7, K_RDRIB, 0};
      4'd6:  return '{2503292, 2202897, 49516, 2, 20, 7, K_LDRIB, 0};
      4'd7:  return '{3748328, 2896036, 273254, 1, 20, 7, K_BACK, 0};
      4'd8:  return '{3748328, 2896036, 273254, 1, 20, 2, K_BACK, 0};
      4'd9:  return '{938734, 3744209, 46216, 3, 30, 7, K_TURN, 1};
      4'd10: return '{938734, 3744209, 46216, 3, 30, 7, K_TURN, 0};
      4'd11: return '{281620, 2732163, 128742, 3, 30, 7, K_IN, 1};
      4'd12: return '{281620, 2732163, 128742, 3, 30, 7, K_IN, 0};
      4'd13: return '{750987, 3744209, 46216, 3, 30, 7, K_SIDE, 1};
      4'd14: return '{750987, 3744209, 46216, 3, 30, 7, K_SIDE, 0};
      default: return '{0, 0, 0, 3, 20, 7, K_NONE, 0};
    endcase
  endfunction

  function automatic pose_t next_pose(input bit tk);
    gait_params_t p;
    longint j [12];
    longint c, l, g, s, off;
    int unsigned ts, ph, ps, level, cap;
    int side;
    pose_t r;
    p = params_of(gait_sel);
    foreach (j[k]) j[k] = 0;
    ts = tick_count;
    ph = (p.cyc * ts) % 360;
    ps = p.shifted ? (ph + 180) % 360 : ph;
    level = amp_level;
    c = sine_deg(ps + 90);
    if (p.kind inside {K_TURN, K_IN, K_SIDE}) level = 0;
    if (p.kind <= K_LDRIB) begin
      l = round_shift(round_shift(p.amp * sigmoid_tab[p.sig][level], 16) * c, 14);
      off = round_shift(l * 6554, 16);
      case (p.kind)
        K_FWD: begin j[2] -= l; j[4] += l; j[8] += l; j[10] -= l; end
        K_BACK: begin j[2] += l; j[4] -= l; j[8] -= l; j[10] += l; end
        K_RDRIB: begin j[8] += l; j[10] -= l; j[2] -= off; j[4] += off; end
        default: begin j[2] -= l; j[4] += l; j[8] += off; j[10] -= off; end
      endcase
    end else if (p.kind != K_NONE) begin
      l = round_shift(p.amp * (16384 - c), 14);
      if (p.kind == K_TURN) begin
        j[0] = -l; j[6] = -l;
      end else begin
        j[1] -= l; j[5] += l; j[7] += l; j[11] -= l;
        if (p.kind == K_IN) begin
          l = round_shift(longint'(1314228) * c, 14);
          j[2] -= l; j[4] += l; j[8] -= l; j[10] += l;
        end
      end
    end
    g = round_shift(p.grav * sine_deg(ph), 14);
    s = round_shift(p.spring * (16384 - sine_deg((2 * p.cyc * ts) % 360 + 90)), 14);
    // sway sign picks which leg takes the spring bend
    side = (g > 0) ? 0 : 6;
    j[side + 2] += s; j[side + 3] -= 2 * s; j[side + 4] += s;
    if (j[3] >= 0) j[3] = 0;
    if (j[9] >= 0) j[9] = 0;

    if (tk) begin
      if (p.kind == K_NONE) level = amp_level;
      if (longint'(ts) * p.cyc >= longint'(period_idx) * 360) begin
        if (period_idx < 8191) period_idx++;
        cap = (p.cap < MAX_LEVEL) ? p.cap : MAX_LEVEL;
        if (drive_dir && level < cap) level++;
        if (!drive_dir && level > 1) level--;
      end
      amp_level = level & 7;
      if (ts > p.cyc * 100) done_flag = 1'b1;
      if (tick_count < 16'hFFFF) tick_count++;
    end

    r.joint[0] = to_angle(j[0]);
    r.joint[1] = to_angle(j[1] - g);
    r.joint[2] = to_angle(j[2]);
    r.joint[3] = to_angle(j[3]);
    r.joint[4] = to_angle(j[4]);
    r.joint[5] = to_angle(j[5] + g);
    r.joint[6] = to_angle(j[7] - g);
    r.joint[7] = to_angle(j[8]);
    r.joint[8] = to_angle(j[9]);
    r.joint[9] = to_angle(j[10]);
    r.joint[10] = to_angle(j[11] + g);
    r.fin = done_flag;
    return r;
  endfunction

  // ---------------- driver, receiver, monitor ----------------
  bit    tick_queue [$];
  pose_t pending_poses [$];
  int    fail_count = 0;
  bit    quiet = 1'b0;
  bit    hold_request = 1'b0;
  bit    hold_taken = 1'b0;
  int    send_gap = 0;
  int    hold_left = 0;
  int    stall_left = 0;
  int    idle_cycles = 0;

  always @(posedge clk or negedge rst_n) begin
    logic nxt_valid;
    logic nxt_tick;
    if (!rst_n) begin
      in_valid <= 1'b0;
      tick <= 1'b0;
    end else begin
      nxt_valid = in_valid;
      nxt_tick = tick;
      if (in_valid && in_ready) begin
        pending_poses.push_back(next_pose(tick));
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (tick_queue.size() > 0) begin
          if (!quiet && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(0, 3);
          end else begin
            nxt_valid = 1'b1;
            nxt_tick = tick_queue.pop_front();
          end
        end
      end
      in_valid <= nxt_valid;
      tick <= nxt_tick;
    end
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_request && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left = LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    pose_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_poses.size() == 0) begin
        $error("unexpected pose transaction");
        fail_count++;
      end else begin
        want = pending_poses.pop_front();
        for (int k = 0; k < 11; k++) begin
          if (joint_seen[k] !== want.joint[k]) begin
            $error("%s: expected %0d, got %0d", joint_name[k], want.joint[k],
                   joint_seen[k]);
            fail_count++;
          end
        end
        if (finished !== want.fin) begin
          $error("finished: expected %0d, got %0d", want.fin, finished);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("gait_trajectory_generator_top: mismatch");
        $finish;
      end
    end
  end

  // ---------------- phases ----------------
  task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_GAIT_MODE) gait_sel = val;
    else drive_dir = val[0];
  endtask

  task automatic drain();
    wait (tick_queue.size() == 0 && !in_valid);
    wait (pending_poses.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic run_phase(input logic [3:0] m, input bit up, input int n, input int zero_odds);
    write_reg(CFG_GAIT_MODE, m);
    write_reg(CFG_DRIVE_UP, {3'b0, up});
    repeat (n) tick_queue.push_back($urandom_range(0, zero_odds) != 0);
    drain();
  endtask

  initial begin
    int sent;
    int n;
    gait_sel = 4'd0;
    drive_dir = 1'b1;
    tick_count = 0;
    amp_level = 1;
    period_idx = 1;
    done_flag = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // pose at reset, then a first tick
    tick_queue.push_back(1'b0);
    tick_queue.push_back(1'b1);
    drain();
    // one item in every mode (tick of one or zero at random), unused mode included, then two zero ticks
    for (int m = 0; m < 16; m++) run_phase(m[3:0], m[0], 1, 1);
    run_phase(4'd0, 1'b1, 2, 0);

    // receiver holds off while items keep coming
    hold_request = 1'b1;
    run_phase(4'd0, 1'b1, 150, 7);

    sent = 170;
    while (sent < 1700) begin
      n = $urandom_range(40, 220);
      run_phase(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), n, 7);
      sent += n;
    end
    // long forward walk past the finish count, the last part with no idling
    run_phase(4'd0, 1'b0, 60, 15);
    quiet = 1'b1;
    run_phase(4'd0, 1'b1, int'(2100 - tick_count), 31);

    repeat (30) @(posedge clk);
    if (fail_count == 0) begin
      $display("gait_trajectory_generator_top: match");
    end else begin
      $display("gait_trajectory_generator_top: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
sv/gtg_pkg.sv
sv/gtg_ctrl.sv
sv/gtg_dp.sv
sv/gait_trajectory_generator_top.sv
sim/testbench.sv
